/* hdl/b64c_pkg.sv */
package b64c_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SYM = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3d;

    // One unit of work for the back end: up to four output words.
    typedef struct packed {
        logic [3:0][7:0] data;     // data[0] goes out first
        logic [1:0]      last_idx; // index of the final word of this job
        logic            last;
        logic [1:0]      status;
    } t_job;

    function automatic logic [7:0] enc_symbol(input logic [5:0] v);
        logic [7:0] s;
        if (v < 6'd26) begin
            s = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            s = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            s = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            s = 8'h2b;
        end else begin
            s = 8'h2f;
        end
        return s;
    endfunction

    // bit 6 set means not in the alphabet
    function automatic logic [6:0] dec_symbol(input logic [7:0] c);
        logic [6:0] v;
        if (c >= 8'h41 && c <= 8'h5a) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            v = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2b) begin
            v = 7'd62;
        end else if (c == 8'h2f) begin
            v = 7'd63;
        end else begin
            v = 7'd64;
        end
        return v;
    endfunction

endpackage

/* hdl/b64c_ifs.sv */
interface b64c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output out_last, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input status,
                    output ready);
endinterface

/* hdl/b64c_front.sv */
module b64c_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    b64c_in_if.sink      i_in,
    input  logic         i_q_full,
    output logic         o_push,
    output b64c_pkg::t_job o_job
);
    import b64c_pkg::*;

    logic        r_dir;
    logic [1:0]  r_pos;
    logic [23:0] r_bits;
    logic [1:0]  r_pad;
    logic        r_err;

    logic [1:0]  n_pos;
    logic [23:0] n_bits;
    logic [1:0]  n_pad;
    logic        n_err;
    logic        n_push;
    t_job        n_job;

    logic        accept;
    logic [7:0]  c;
    logic [2:0]  enc_cnt;
    logic [23:0] enc_bits;
    logic [6:0]  v;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign c          = i_in.in_byte;
    assign v          = dec_symbol(c);

    always_comb begin
        n_pos    = r_pos;
        n_bits   = r_bits;
        n_pad    = r_pad;
        n_err    = r_err;
        n_push   = 1'b0;
        n_job    = '0;
        enc_bits = r_bits;
        enc_cnt  = 3'd0;
        if (r_dir == DIR_ENCODE) begin
            case (r_pos)
                2'd1:    enc_bits = r_bits | {8'h00, c, 8'h00};
                2'd2:    enc_bits = r_bits | {16'h0000, c};
                default: enc_bits = r_bits | {c, 16'h0000};
            endcase
            enc_cnt = (r_pos > 2'd2) ? 3'd1 : {1'b0, r_pos} + 3'd1;
            if (enc_cnt == 3'd3 || i_in.in_last) begin
                n_push          = 1'b1;
                n_job.data[0]   = enc_symbol(enc_bits[23:18]);
                n_job.data[1]   = enc_symbol(enc_bits[17:12]);
                n_job.data[2]   = (enc_cnt >= 3'd2) ? enc_symbol(enc_bits[11:6]) : PAD_CHAR;
                n_job.data[3]   = (enc_cnt == 3'd3) ? enc_symbol(enc_bits[5:0]) : PAD_CHAR;
                n_job.last_idx  = 2'd3;
                n_job.last      = i_in.in_last;
                n_job.status    = ST_OK;
                n_pos           = 2'd0;
                n_bits          = '0;
            end else begin
                n_pos  = enc_cnt[1:0];
                n_bits = enc_bits;
            end
        end else begin
            if (!r_err) begin
                if (c == PAD_CHAR) begin
                    if (r_pos == 2'd2 && r_pad == 2'd0) begin
                        n_pad = 2'd1;
                    end else if (r_pos == 2'd3 && r_pad <= 2'd1) begin
                        n_pad = r_pad + 2'd1;
                    end else begin
                        n_err = 1'b1;
                    end
                end else if (v[6] || r_pad != 2'd0) begin
                    n_err = 1'b1;
                end else begin
                    case (r_pos)
                        2'd0:    n_bits = r_bits | {v[5:0], 18'd0};
                        2'd1:    n_bits = r_bits | {6'd0, v[5:0], 12'd0};
                        2'd2:    n_bits = r_bits | {12'd0, v[5:0], 6'd0};
                        default: n_bits = r_bits | {18'd0, v[5:0]};
                    endcase
                end
                if (!n_err) begin
                    if (r_pos == 2'd3) begin
                        // group complete: 3, 2 or 1 bytes depending on padding
                        n_push         = 1'b1;
                        n_job.data[0]  = n_bits[23:16];
                        n_job.data[1]  = n_bits[15:8];
                        n_job.data[2]  = n_bits[7:0];
                        n_job.data[3]  = 8'h00;
                        n_job.last_idx = 2'd2 - n_pad;
                        n_job.status   = ST_OK;
                        n_pos          = 2'd0;
                        n_bits         = '0;
                    end else begin
                        n_pos = r_pos + 2'd1;
                    end
                end
            end
            if (i_in.in_last) begin
                if (n_err) begin
                    n_push       = 1'b1;
                    n_job        = '0;
                    n_job.last   = 1'b1;
                    n_job.status = ST_BAD_SYM;
                end else if (n_pos != 2'd0) begin
                    n_push       = 1'b1;
                    n_job        = '0;
                    n_job.last   = 1'b1;
                    n_job.status = ST_BAD_LEN;
                end else begin
                    n_job.last = n_push;
                end
            end
        end
        if (i_in.in_last) begin
            n_pos  = 2'd0;
            n_bits = '0;
            n_pad  = 2'd0;
            n_err  = 1'b0;
        end
    end

    assign o_push = accept && n_push;
    assign o_job  = n_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_ENCODE;
            r_pos  <= 2'd0;
            r_bits <= '0;
            r_pad  <= 2'd0;
            r_err  <= 1'b0;
        end else if (i_cfg_we) begin
            // new direction starts a new message
            r_dir  <= i_cfg_wdata;
            r_pos  <= 2'd0;
            r_bits <= '0;
            r_pad  <= 2'd0;
            r_err  <= 1'b0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_bits <= n_bits;
            r_pad  <= n_pad;
            r_err  <= n_err;
        end
    end

endmodule

/* hdl/b64c_queue.sv */
module b64c_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64c_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output b64c_pkg::t_job o_head
);
    import b64c_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/b64c_back.sv */
module b64c_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  b64c_pkg::t_job i_head,
    output logic           o_pop,
    b64c_out_if.source     o_out
);
    import b64c_pkg::*;

    logic [1:0] r_idx;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic [1:0] r_ostatus;
    logic       load;
    logic       at_end;

    assign load   = !r_ovalid || o_out.ready;
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = load && !i_q_empty && at_end;

    assign o_out.valid    = r_ovalid;
    assign o_out.out_byte = r_obyte;
    assign o_out.out_last = r_olast;
    assign o_out.status   = r_ostatus;

    always_ff @(posedge i_clk) begin
        if (load && !i_q_empty) begin
            r_obyte   <= i_head.data[r_idx];
            r_olast   <= i_head.last && at_end;
            r_ostatus <= i_head.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= 2'd0;
        end else if (load) begin
            r_ovalid <= !i_q_empty;
            if (!i_q_empty) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

endmodule

/* hdl/base64_codec_unit.sv */
// Streaming base64 codec, standard alphabet with '=' padding.
// i_in carries one word per item (in_byte, in_last); o_out carries result
// words (out_byte, out_last, status). Both use valid/ready; a word moves on
// a clock edge with both high. i_cfg_we/i_cfg_wdata write the direction
// (0 encode, 1 decode) and start a new message; write only while idle.
// Encode: every third byte, or a byte with in_last, yields four symbols.
// Decode: every fourth symbol yields one to three bytes; a bad symbol or a
// short final group yields a single word with status set and out_last high.
// Results are written to the job queue and then loaded into the output
// register, where the first result word turns valid.
// Throughput: the back end sends one word per cycle while the receiver is
// ready, so in encode the four symbols per group hold the input back, and
// decode takes one symbol per cycle; the input is taken at one word per cycle
// while the job queue has room. Reset (synchronous, active low) clears group
// state, the queue and the output valid flag; direction returns to encode.
// When the receiver stalls, the output register holds its word, the job
// queue fills, and i_in.ready drops once the queue is full.
module base64_codec_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    b64c_in_if.sink     i_in,
    b64c_out_if.source  o_out
);
    import b64c_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_job front_job;
    t_job head_job;

    b64c_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (front_job)
    );

    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    b64c_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

/* hdl/b64c_checker.sv */
module b64c_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_byte,
    input logic       i_last,
    input logic [1:0] i_status
);
    import b64c_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("output word dropped while stalled");

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_byte))
        else $error("output word changed while stalled");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != ST_OK |-> i_last)
        else $error("error status on a word that does not end the message");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != ST_OK |-> i_byte == 8'h00)
        else $error("error word carries data");

endmodule

bind base64_codec_unit b64c_checker u_b64c_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_byte   (o_out.out_byte),
    .i_last   (o_out.out_last),
    .i_status (o_out.status)
);
